/* sv/cacd_pkg.sv */
// ----------------------------------------------------------------------------
// cacd_pkg
// Types and constants shared by the color/attribute code decoder.
// ----------------------------------------------------------------------------
package cacd_pkg;

  // control bytes
  localparam logic [7:0] B_COLOR  = 8'h19;
  localparam logic [7:0] B_SET    = 8'h1A;
  localparam logic [7:0] B_CLR    = 8'h1B;
  localparam logic [7:0] B_RESET  = 8'h1C;
  localparam logic [7:0] B_ZERO   = 8'h30;

  // configuration register indexes
  localparam logic [1:0] CFG_STD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_EXT_COUNT = 2'd1;
  localparam logic [1:0] CFG_DEF_FG    = 2'd2;
  localparam logic [1:0] CFG_DEF_BG    = 2'd3;

  // parser states
  localparam logic [3:0] P_IDLE     = 4'd0;
  localparam logic [3:0] P_ESC      = 4'd1;
  localparam logic [3:0] P_FG_SEL   = 4'd2;
  localparam logic [3:0] P_FG_ATTR  = 4'd3;
  localparam logic [3:0] P_FG_SKIP  = 4'd4;
  localparam logic [3:0] P_BG_SEL   = 4'd5;
  localparam logic [3:0] P_BG_SKIP  = 4'd6;
  localparam logic [3:0] P_BG_ATTR  = 4'd7;
  localparam logic [3:0] P_DIGITS   = 4'd8;
  localparam logic [3:0] P_PAIR     = 4'd9;
  localparam logic [3:0] P_PAIR_SEL = 4'd10;
  localparam logic [3:0] P_SET_RUN  = 4'd11;
  localparam logic [3:0] P_CLR_RUN  = 4'd12;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
    logic       fg_valid;
    logic [9:0] fg_index;
    logic       fg_extended;
    logic       bg_valid;
    logic [9:0] bg_index;
    logic       bg_extended;
    logic       bold;
    logic       italic;
    logic       underline;
    logic       last_of_run;
  } res_t;

endpackage

/* sv/color_attribute_code_decoder_unit.sv */
// ----------------------------------------------------------------------------
// color_attribute_code_decoder_unit
// Splits formatted chat text into text bytes and attribute snapshots.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | data_byte, last_byte
//  out_    | out       | out_valid/out_stall| kind .. last_of_run
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Each byte is decoded in the cycle it is accepted; its 0 to 4 results are
//  loaded into a 4-deep result buffer and leave one per cycle.
//  A new byte is taken when the buffer is empty or its last entry leaves in
//  that cycle, so bytes with at most one result stream at one per cycle;
//  a byte with more results holds off the next byte until its results drain. Reset is synchronous, no sweep.
//  out_stall holds the buffer; in_stall follows the buffer level.
module color_attribute_code_decoder_unit
  import cacd_pkg::*;
#(
  parameter int STD_DIGITS = 2,
  parameter int EXT_DIGITS = 5,
  parameter int INDEX_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_char_byte,
  output logic        out_fg_valid,
  output logic [9:0]  out_fg_index,
  output logic        out_fg_extended,
  output logic        out_bg_valid,
  output logic [9:0]  out_bg_index,
  output logic        out_bg_extended,
  output logic        out_bold,
  output logic        out_italic,
  output logic        out_underline,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int ACC_W = 4 * EXT_DIGITS + 4;
  localparam logic [9:0] IMASK = (INDEX_BITS >= 10) ? 10'h3FF : 10'((1 << INDEX_BITS) - 1);
  localparam logic [2:0] STD_N = 3'(STD_DIGITS);
  localparam logic [2:0] EXT_N = 3'(EXT_DIGITS);

  logic [10:0] std_limit_r, ext_count_r;
  logic [9:0]  def_fg_r, def_bg_r;

  logic [3:0]         st_r;
  logic [2:0]         dl_r;
  logic [ACC_W-1:0]   acc_r;
  logic [1:0]         u8_r;
  logic               fon_r, fext_r, bon_r, bext_r;
  logic [10:0]        fcol_r, bcol_r;
  logic [3:0]         fl_r;
  logic               sbg_r, sext_r, pm_r;

  res_t       res_r [MAX_RES];
  logic [2:0] cnt_r;

  res_t       r [MAX_RES];
  logic [2:0] n;

  logic [3:0]         st;
  logic [2:0]         dl;
  logic [ACC_W-1:0]   acc;
  logic [1:0]         u8;
  logic               fon, fext, bon, bext;
  logic [10:0]        fcol, bcol;
  logic [3:0]         fl;
  logic               sbg, sext, pm;

  logic in_acc, out_pop;

  function automatic res_t snap(input logic fv, input logic [10:0] fi, input logic fe,
                                input logic bv, input logic [10:0] bi, input logic be,
                                input logic [3:0] f);
    res_t s;
    logic       v1, e1, v2, e2;
    logic [10:0] i1, i2;
    s = '0;
    v1 = fv; i1 = fi; e1 = fe;
    v2 = bv; i2 = bi; e2 = be;
    if (f[1]) begin
      v2 = 1'b1; i2 = fv ? fi : 11'd0; e2 = fv & fe;
      v1 = 1'b1; i1 = bv ? bi : 11'd1; e1 = bv & be;
    end
    s.kind = 1'b1;
    if (v1) begin
      s.fg_valid = 1'b1; s.fg_index = i1[9:0] & IMASK; s.fg_extended = e1;
    end
    if (v2) begin
      s.bg_valid = 1'b1; s.bg_index = i2[9:0] & IMASK; s.bg_extended = e2;
    end
    s.bold      = f[0];
    s.italic    = f[2];
    s.underline = f[3];
    return s;
  endfunction

  function automatic res_t text(input logic [7:0] b);
    res_t s;
    s = '0;
    s.char_byte = b;
    return s;
  endfunction

  // {hit, flag number}
  function automatic logic [2:0] mark_of(input logic [7:0] b);
    logic [2:0] m;
    m = 3'b000;
    if (b == 8'h01 || b == "*") m = 3'b100;
    else if (b == 8'h02 || b == "!") m = 3'b101;
    else if (b == 8'h03 || b == "/") m = 3'b110;
    else if (b == 8'h04 || b == "_") m = 3'b111;
    return m;
  endfunction

  function automatic logic skip_ch(input logic [7:0] b);
    return b == "@" || b == "*" || b == "!" || b == "/" || b == "_" || b == "|";
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  mk;
    logic        do_set, do_clr, do_start, do_add, do_idle, on;
    logic [10:0] idx;
    logic signed [ACC_W-1:0] c;
    b = in_data_byte;
    mk = mark_of(b);
    do_set = 1'b0; do_clr = 1'b0; do_start = 1'b0; do_add = 1'b0; do_idle = 1'b0;
    on = 1'b0; idx = '0; c = '0;
    st = st_r; dl = dl_r; acc = acc_r; u8 = u8_r;
    fon = fon_r; fcol = fcol_r; fext = fext_r;
    bon = bon_r; bcol = bcol_r; bext = bext_r;
    fl = fl_r; sbg = sbg_r; sext = sext_r; pm = pm_r;
    for (int i = 0; i < MAX_RES; i++) r[i] = '0;
    n = 3'd0;

    unique case (st_r)
      P_ESC: begin
        sbg = 1'b0; sext = 1'b0; pm = 1'b0;
        if (b == "F") st = P_FG_SEL;
        else if (b == "B") st = P_BG_SEL;
        else if (b == "*") begin
          pm = 1'b1; st = P_FG_SEL;
        end else if (b == "@") begin
          sext = 1'b1; st = P_FG_SKIP;
        end else if (b == B_RESET) begin
          fon = 1'b0; bon = 1'b0;
          r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
          st = P_IDLE;
        end else begin
          st = P_FG_SKIP;
          do_start = !skip_ch(b);
        end
      end
      P_FG_SEL, P_FG_ATTR: begin
        if (st_r == P_FG_SEL) sbg = 1'b0;
        if (st_r == P_FG_SEL && b == "@") begin
          sext = 1'b1; st = P_FG_ATTR;
        end else begin
          if (st_r == P_FG_SEL) sext = 1'b0;
          st = P_FG_ATTR;
          if (mk[2] || b == "|" || b == "@" || b == B_SET) do_set = 1'b1;
          else do_start = 1'b1;
        end
      end
      P_FG_SKIP: begin
        do_start = !skip_ch(b);
      end
      P_BG_SEL, P_BG_SKIP: begin
        if (st_r == P_BG_SEL) begin
          sbg = 1'b1; pm = 1'b0; sext = (b == "@");
        end
        st = P_BG_SKIP;
        do_start = !(skip_ch(b) || b == "," || b == "~");
      end
      P_PAIR_SEL, P_BG_ATTR: begin
        if (st_r == P_PAIR_SEL) begin
          sbg = 1'b1; pm = 1'b0;
        end
        if (st_r == P_PAIR_SEL && b == "@") begin
          sext = 1'b1; st = P_BG_ATTR;
        end else begin
          if (st_r == P_PAIR_SEL) sext = 1'b0;
          st = P_BG_ATTR;
          if (mk[2] || b == "|" || b == "@" || b == B_SET) do_set = 1'b1;
          else if (b == "," || b == "~") st = P_BG_SKIP;
          else do_start = 1'b1;
        end
      end
      P_DIGITS: do_add = 1'b1;
      P_PAIR: begin
        if (b == "," || b == "~") st = P_PAIR_SEL;
        else begin
          st = P_IDLE; pm = 1'b0; do_idle = 1'b1;
        end
      end
      P_SET_RUN: begin
        if (mk[2] || b == "|" || b == "@" || b == B_SET) do_set = 1'b1;
        else begin
          st = P_IDLE; do_idle = 1'b1;
        end
      end
      P_CLR_RUN: begin
        if (mk[2] || b == "|" || b == B_CLR) do_clr = 1'b1;
        else begin
          st = P_IDLE; do_idle = 1'b1;
        end
      end
      default: begin
        st = P_IDLE; do_idle = 1'b1;
      end
    endcase

    if (do_set && mk[2] && !fl[mk[1:0]]) begin
      fl[mk[1:0]] = 1'b1;
      r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
    end
    if (do_clr && mk[2] && fl[mk[1:0]]) begin
      fl[mk[1:0]] = 1'b0;
      r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
    end

    if (do_start) begin
      dl = sext ? EXT_N : STD_N;
      acc = '0;
      st = P_DIGITS;
      do_add = 1'b1;
    end
    if (do_add) begin
      acc = (acc << 3) + (acc << 1) + ACC_W'(b) - ACC_W'(B_ZERO);
      if (dl != 3'd0) dl = dl - 3'd1;
      if (dl == 3'd0) begin
        c = $signed(acc);
        if (sext) begin
          if (c >= 0 && c < $signed({{(ACC_W-11){1'b0}}, ext_count_r})) begin
            on = 1'b1; idx = acc[10:0];
          end
        end else if (c == 0) begin
          on = 1'b1; idx = {1'b0, sbg ? def_bg_r : def_fg_r};
        end else if (c > 0 && c < $signed({{(ACC_W-11){1'b0}}, std_limit_r})) begin
          on = 1'b1; idx = acc[10:0];
        end
        if (sbg) begin
          bon = on; bcol = on ? idx : 11'd0; bext = on & sext;
        end else begin
          fon = on; fcol = on ? idx : 11'd0; fext = on & sext;
        end
        r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
        acc = '0;
        st = pm ? P_PAIR : P_IDLE;
      end
    end

    if (do_idle) begin
      if (u8 != 2'd0) begin
        u8 = u8 - 2'd1;
        r[n[1:0]] = text(b); n = n + 3'd1;
      end else if (b == B_COLOR) st = P_ESC;
      else if (b == B_RESET) begin
        fon = 1'b0; bon = 1'b0;
        r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
        fl = '0;
        r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
      end else if (b == B_SET) st = P_SET_RUN;
      else if (b == B_CLR) st = P_CLR_RUN;
      else if (b != 8'h00) begin
        if (b[7:3] == 5'b11110) u8 = 2'd3;
        else if (b[7:4] == 4'b1110) u8 = 2'd2;
        else if (b[7:5] == 3'b110) u8 = 2'd1;
        r[n[1:0]] = text(b); n = n + 3'd1;
      end
    end

    if (in_last_byte) begin
      st = P_IDLE; dl = '0; acc = '0; u8 = '0;
      sbg = 1'b0; sext = 1'b0; pm = 1'b0;
      fon = 1'b0; bon = 1'b0;
      r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
      fl = '0;
      r[n[1:0]] = snap(fon, fcol, fext, bon, bcol, bext, fl); n = n + 3'd1;
      fcol = '0; bcol = '0; fext = 1'b0; bext = 1'b0;
    end

    if (n != 3'd0) r[2'(n - 3'd1)].last_of_run = 1'b1;
  end

  assign out_valid = (cnt_r != 3'd0);
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 3'd0) || (cnt_r == 3'd1 && !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_limit_r <= 11'd17;
      ext_count_r <= 11'd256;
      def_fg_r    <= '0;
      def_bg_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STD_LIMIT: std_limit_r <= cfg_data;
        CFG_EXT_COUNT: ext_count_r <= cfg_data;
        CFG_DEF_FG:    def_fg_r    <= cfg_data[9:0];
        CFG_DEF_BG:    def_bg_r    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE; dl_r <= '0; acc_r <= '0; u8_r <= '0;
      fon_r <= 1'b0; fcol_r <= '0; fext_r <= 1'b0;
      bon_r <= 1'b0; bcol_r <= '0; bext_r <= 1'b0;
      fl_r <= '0; sbg_r <= 1'b0; sext_r <= 1'b0; pm_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        st_r <= st; dl_r <= dl; acc_r <= acc; u8_r <= u8;
        fon_r <= fon; fcol_r <= fcol; fext_r <= fext;
        bon_r <= bon; bcol_r <= bcol; bext_r <= bext;
        fl_r <= fl; sbg_r <= sbg; sext_r <= sext; pm_r <= pm;
        cnt_r <= n;
      end else if (out_pop) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  // result buffer, head at entry 0
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RES; i++) res_r[i] <= r[i];
    end else if (out_pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) res_r[i] <= res_r[i+1];
    end
  end

  assign out_kind        = res_r[0].kind;
  assign out_char_byte   = res_r[0].char_byte;
  assign out_fg_valid    = res_r[0].fg_valid;
  assign out_fg_index    = res_r[0].fg_index;
  assign out_fg_extended = res_r[0].fg_extended;
  assign out_bg_valid    = res_r[0].bg_valid;
  assign out_bg_index    = res_r[0].bg_index;
  assign out_bg_extended = res_r[0].bg_extended;
  assign out_bold        = res_r[0].bold;
  assign out_italic      = res_r[0].italic;
  assign out_underline   = res_r[0].underline;
  assign out_last_of_run = res_r[0].last_of_run;

endmodule

/* sv/cacd_checker.sv */
// ----------------------------------------------------------------------------
// cacd_assertions
// Port-level checks for the color/attribute code decoder.
// ----------------------------------------------------------------------------
module cacd_assertions (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_char_byte,
  input logic       out_fg_valid,
  input logic [9:0] out_fg_index,
  input logic       out_fg_extended,
  input logic       out_bg_valid,
  input logic [9:0] out_bg_index,
  input logic       out_bg_extended,
  input logic       out_bold,
  input logic       out_italic,
  input logic       out_underline
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_byte) && $stable(out_kind))
    else $error("stalled item changed");

  a_text_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_fg_valid && !out_bg_valid && !out_bold &&
                               !out_italic && !out_underline)
    else $error("text item carries attributes");

  a_snap_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_char_byte == 8'd0)
    else $error("snapshot carries a char");

  a_color_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_fg_valid || !out_bg_valid) |->
      (out_fg_valid || (out_fg_index == 10'd0 && !out_fg_extended)) &&
      (out_bg_valid || (out_bg_index == 10'd0 && !out_bg_extended)))
    else $error("invalid color has index");

endmodule

bind color_attribute_code_decoder_unit cacd_assertions u_cacd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_kind(out_kind), .out_char_byte(out_char_byte),
  .out_fg_valid(out_fg_valid), .out_fg_index(out_fg_index),
  .out_fg_extended(out_fg_extended), .out_bg_valid(out_bg_valid),
  .out_bg_index(out_bg_index), .out_bg_extended(out_bg_extended),
  .out_bold(out_bold), .out_italic(out_italic), .out_underline(out_underline)
);

/* tb/cacd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cacd_checker
// Watches the byte and result channels of the color/attribute code decoder,
// computes the expected text bytes and attribute snapshots for every
// accepted byte and compares them in order with the results that leave.
// ----------------------------------------------------------------------------
module cacd_checker
  import cacd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  res_t        out_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  res_t expected_q[$];

  // decoder copy
  logic [10:0] std_limit, ext_count;
  logic [9:0]  def_fg, def_bg;
  logic [3:0]  pstate;
  int          digits_left, accum, utf8_left;
  logic        fg_on, bg_on, fg_x, bg_x;
  logic [10:0] fg_col, bg_col;
  logic [3:0]  flags;
  logic        sel_bg, sel_ext, pair_mode;
  int          n_made;

  assign pending = expected_q.size();

  function automatic int mark_pos(logic [7:0] b);
    if (b == 8'h01 || b == "*") return 0;
    if (b == 8'h02 || b == "!") return 1;
    if (b == 8'h03 || b == "/") return 2;
    if (b == 8'h04 || b == "_") return 3;
    return -1;
  endfunction

  task automatic push_res(logic knd, logic [7:0] ch);
    res_t r;
    logic fv, fe, bv, be, ov, oe;
    logic [10:0] fi, bi, oi;
    r = '0;
    fv = fg_on; fe = fg_x; bv = bg_on; be = bg_x; fi = fg_col; bi = bg_col;
    r.kind = knd;
    if (!knd) begin
      r.char_byte = ch;
    end else begin
      if (flags[1]) begin
        ov = bv; oe = be; oi = bi;
        if (!fv) begin bi = 0; be = 0; end else begin bi = fi; be = fe; end
        bv = 1;
        if (!ov) begin fi = 1; fe = 0; end else begin fi = oi; fe = oe; end
        fv = 1;
      end
      if (fv) begin r.fg_valid = 1; r.fg_index = fi[9:0]; r.fg_extended = fe; end
      if (bv) begin r.bg_valid = 1; r.bg_index = bi[9:0]; r.bg_extended = be; end
      r.bold = flags[0];
      r.italic = flags[2];
      r.underline = flags[3];
    end
    expected_q.push_back(r);
    n_made++;
  endtask

  task automatic snap_end_colors();
    fg_on = 0; bg_on = 0;
    push_res(1'b1, 8'h00);
  endtask

  task automatic snap_end_attrs();
    flags = 0;
    push_res(1'b1, 8'h00);
  endtask

  task automatic set_mark(logic [7:0] b, output logic took);
    int k;
    k = mark_pos(b);
    took = 1;
    if (k >= 0) begin
      if (!flags[k]) begin flags[k] = 1; push_res(1'b1, 8'h00); end
    end else begin
      took = (b == "|" || b == "@" || b == B_SET);
    end
  endtask

  task automatic clear_mark(logic [7:0] b, output logic took);
    int k;
    k = mark_pos(b);
    took = 1;
    if (k >= 0) begin
      if (flags[k]) begin flags[k] = 0; push_res(1'b1, 8'h00); end
    end else begin
      took = (b == "|" || b == B_CLR);
    end
  endtask

  task automatic take_digit(logic [7:0] b);
    logic on;
    logic [10:0] idx;
    accum = accum * 10 + (int'(b) - 48);
    if (digits_left > 0) digits_left--;
    if (digits_left == 0) begin
      on = 0; idx = 0;
      if (sel_ext) begin
        if (accum >= 0 && accum < int'(ext_count)) begin on = 1; idx = 11'(accum); end
      end else if (accum == 0) begin
        on = 1; idx = sel_bg ? {1'b0, def_bg} : {1'b0, def_fg};
      end else if (accum > 0 && accum < int'(std_limit)) begin
        on = 1; idx = 11'(accum);
      end
      if (sel_bg) begin
        bg_on = on; bg_col = on ? idx : 0; bg_x = on && sel_ext;
      end else begin
        fg_on = on; fg_col = on ? idx : 0; fg_x = on && sel_ext;
      end
      push_res(1'b1, 8'h00);
      accum = 0;
      pstate = pair_mode ? P_PAIR : P_IDLE;
    end
  endtask

  task automatic first_digit(logic [7:0] b);
    digits_left = sel_ext ? 5 : 2;
    accum = 0;
    pstate = P_DIGITS;
    take_digit(b);
  endtask

  task automatic text_byte(logic [7:0] b);
    if (utf8_left > 0) begin
      utf8_left--;
      push_res(1'b0, b);
    end else if (b == B_COLOR) begin
      pstate = P_ESC;
    end else if (b == B_RESET) begin
      snap_end_colors();
      snap_end_attrs();
    end else if (b == B_SET) begin
      pstate = P_SET_RUN;
    end else if (b == B_CLR) begin
      pstate = P_CLR_RUN;
    end else if (b != 8'h00) begin
      if ((b & 8'hF8) == 8'hF0) utf8_left = 3;
      else if ((b & 8'hF0) == 8'hE0) utf8_left = 2;
      else if ((b & 8'hE0) == 8'hC0) utf8_left = 1;
      push_res(1'b0, b);
    end
  endtask

  function automatic logic fg_skippable(logic [7:0] b);
    return b == "@" || b == "*" || b == "!" || b == "/" || b == "_" || b == "|";
  endfunction

  task automatic fg_skip(logic [7:0] b);
    pstate = P_FG_SKIP;
    if (!fg_skippable(b)) first_digit(b);
  endtask

  task automatic bg_skip(logic [7:0] b);
    pstate = P_BG_SKIP;
    if (!(fg_skippable(b) || b == "," || b == "~")) first_digit(b);
  endtask

  task automatic fg_attr(logic [7:0] b);
    logic took;
    pstate = P_FG_ATTR;
    set_mark(b, took);
    if (!took) first_digit(b);
  endtask

  task automatic bg_attr(logic [7:0] b);
    logic took;
    pstate = P_BG_ATTR;
    set_mark(b, took);
    if (!took) begin
      if (b == "," || b == "~") pstate = P_BG_SKIP;
      else first_digit(b);
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic lst);
    logic took;
    int first;
    first = expected_q.size();
    n_made = 0;
    case (pstate)
      P_ESC: begin
        sel_bg = 0; sel_ext = 0; pair_mode = 0;
        if (b == "F") pstate = P_FG_SEL;
        else if (b == "B") pstate = P_BG_SEL;
        else if (b == "*") begin pair_mode = 1; pstate = P_FG_SEL; end
        else if (b == "@") begin sel_ext = 1; pstate = P_FG_SKIP; end
        else if (b == B_RESET) begin snap_end_colors(); pstate = P_IDLE; end
        else fg_skip(b);
      end
      P_FG_SEL: begin
        sel_bg = 0;
        if (b == "@") begin sel_ext = 1; pstate = P_FG_ATTR; end
        else begin sel_ext = 0; fg_attr(b); end
      end
      P_FG_ATTR: fg_attr(b);
      P_FG_SKIP: fg_skip(b);
      P_BG_SEL: begin
        sel_bg = 1; pair_mode = 0; sel_ext = (b == "@");
        bg_skip(b);
      end
      P_BG_SKIP: bg_skip(b);
      P_BG_ATTR: bg_attr(b);
      P_DIGITS: take_digit(b);
      P_PAIR: begin
        if (b == "," || b == "~") pstate = P_PAIR_SEL;
        else begin pstate = P_IDLE; pair_mode = 0; text_byte(b); end
      end
      P_PAIR_SEL: begin
        sel_bg = 1; pair_mode = 0;
        if (b == "@") begin sel_ext = 1; pstate = P_BG_ATTR; end
        else begin sel_ext = 0; bg_attr(b); end
      end
      P_SET_RUN: begin
        set_mark(b, took);
        if (!took) begin pstate = P_IDLE; text_byte(b); end
      end
      P_CLR_RUN: begin
        clear_mark(b, took);
        if (!took) begin pstate = P_IDLE; text_byte(b); end
      end
      default: begin pstate = P_IDLE; text_byte(b); end
    endcase
    if (lst) begin
      pstate = P_IDLE; digits_left = 0; accum = 0; utf8_left = 0;
      sel_bg = 0; sel_ext = 0; pair_mode = 0;
      snap_end_colors();
      snap_end_attrs();
      fg_col = 0; bg_col = 0; fg_x = 0; bg_x = 0;
    end
    if (n_made > 0) expected_q[first + n_made - 1].last_of_run = 1'b1;
  endtask

  task automatic compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      std_limit <= 17; ext_count <= 256; def_fg <= 0; def_bg <= 0;
      pstate = P_IDLE; digits_left = 0; accum = 0; utf8_left = 0;
      fg_on = 0; bg_on = 0; fg_x = 0; bg_x = 0; fg_col = 0; bg_col = 0;
      flags = 0; sel_bg = 0; sel_ext = 0; pair_mode = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STD_LIMIT: std_limit <= cfg_data;
          CFG_EXT_COUNT: ext_count <= cfg_data;
          CFG_DEF_FG:    def_fg <= cfg_data[9:0];
          CFG_DEF_BG:    def_bg <= cfg_data[9:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("kind", e.kind, out_res.kind);
          compare_field("char_byte", e.char_byte, out_res.char_byte);
          compare_field("fg_valid", e.fg_valid, out_res.fg_valid);
          compare_field("fg_index", e.fg_index, out_res.fg_index);
          compare_field("fg_extended", e.fg_extended, out_res.fg_extended);
          compare_field("bg_valid", e.bg_valid, out_res.bg_valid);
          compare_field("bg_index", e.bg_index, out_res.bg_index);
          compare_field("bg_extended", e.bg_extended, out_res.bg_extended);
          compare_field("bold", e.bold, out_res.bold);
          compare_field("italic", e.italic, out_res.italic);
          compare_field("underline", e.underline, out_res.underline);
          compare_field("last_of_run", e.last_of_run, out_res.last_of_run);
        end
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_last_byte);
    end
  end

endmodule

/* tb/tb_color_attribute_code_decoder_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_attribute_code_decoder_unit
// Feeds directed and random formatted text (escape sequences, attribute
// runs, UTF-8, noise) under several register settings with random gaps and
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_color_attribute_code_decoder_unit;
  import cacd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_last_byte;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_stall;
  res_t        out_res;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  int          fail_count, pending, cycles, bytes_sent;
  logic        hold_rx;

  color_attribute_code_decoder_unit uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_last_byte,
    .out_valid, .out_stall,
    .out_kind(out_res.kind), .out_char_byte(out_res.char_byte),
    .out_fg_valid(out_res.fg_valid), .out_fg_index(out_res.fg_index),
    .out_fg_extended(out_res.fg_extended), .out_bg_valid(out_res.bg_valid),
    .out_bg_index(out_res.bg_index), .out_bg_extended(out_res.bg_extended),
    .out_bold(out_res.bold), .out_italic(out_res.italic),
    .out_underline(out_res.underline), .out_last_of_run(out_res.last_of_run),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cacd_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_last_byte,
    .out_valid, .out_stall, .out_res, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_color_attribute_code_decoder_unit NOT OK");
      $finish;
    end
  end

  // receiver: random stall per result, plus one long hold-off
  initial begin
    int w;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_stall <= 1;
        repeat (60) @(negedge clk);
        hold_rx = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (bytes_sent > 250 && bytes_sent < 310) w = 0;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // valid stays up between back-to-back items; drain() drops it
  task automatic send_byte(logic [7:0] b, logic lst = 0);
    int w;
    w = (bytes_sent % 80 < 20) ? 0 : $urandom_range(0, 6);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_last_byte <= lst;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [7:0] digit_or_junk();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] mark_byte();
    case ($urandom_range(0, 8))
      0: return "*";  1: return "!";  2: return "/";  3: return "_";
      4: return "|";  5: return 8'h01; 6: return 8'h02; 7: return 8'h03;
      default: return 8'h04;
    endcase
  endfunction

  task automatic send_digits(int cnt);
    repeat (cnt) send_byte(digit_or_junk());
  endtask

  // one well-formed-ish sequence with random content
  task automatic send_sequence();
    int i;
    case ($urandom_range(0, 11))
      0: begin send_byte(B_COLOR); send_byte("F");
        if ($urandom_range(0, 1)) begin send_byte("@"); send_digits(5); end
        else begin if ($urandom_range(0, 2) == 0) send_byte(mark_byte());
          send_digits(2); end
      end
      1: begin send_byte(B_COLOR); send_byte("B");
        if ($urandom_range(0, 1)) begin send_byte("@"); send_digits(5); end
        else send_digits(2);
      end
      2: begin send_byte(B_COLOR); send_byte("*"); send_digits(2);
        if ($urandom_range(0, 3) != 0) begin
          send_byte($urandom_range(0, 1) ? "," : "~");
          if ($urandom_range(0, 1)) begin send_byte("@"); send_digits(5); end
          else begin if ($urandom_range(0, 2) == 0) send_byte(mark_byte());
            send_digits(2); end
        end
      end
      3: begin send_byte(B_COLOR); send_byte("@"); send_digits(5); end
      4: begin send_byte(B_COLOR); send_digits(2); end
      5: begin send_byte(B_SET); repeat ($urandom_range(1, 3)) send_byte(mark_byte()); end
      6: begin send_byte(B_CLR); repeat ($urandom_range(1, 3)) send_byte(mark_byte()); end
      7: send_byte(B_RESET);
      8: begin send_byte(B_COLOR); send_byte(B_RESET); end
      9: begin send_byte(8'($urandom_range(8'hC0, 8'hFF)));
        for (i = 0; i < 3; i++) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      10: send_byte(8'($urandom_range(0, 255)));
      default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    endcase
  endtask

  task automatic random_phase(int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      send_sequence();
      if ($urandom_range(0, 12) == 0) send_byte(8'($urandom_range(0, 255)), 1);
    end
    send_byte("x", 1);
    drain();
  endtask

  initial begin
    cycles = 0; bytes_sent = 0; hold_rx = 0;
    rst_n = 0; in_valid = 0; in_data_byte = 0; in_last_byte = 0;
    cfg_valid = 0; cfg_index = CFG_STD_LIMIT; cfg_data = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // directed: fg/bg, pair, extended, attrs with reverse, utf-8, truncation
    send_byte(8'h00); send_byte(8'hFF); send_byte("A");
    send_byte(B_COLOR); send_byte("F"); send_byte("*"); send_byte("0"); send_byte("5");
    send_byte(B_COLOR); send_byte("B"); send_byte("9"); send_byte("9");
    send_byte(B_SET); send_byte("!"); send_byte("_"); send_byte("@");
    send_byte(B_COLOR); send_byte("*"); send_byte("1"); send_byte("2");
    send_byte("~"); send_byte("@"); send_byte("0"); send_byte("0");
    send_byte("2"); send_byte("5"); send_byte("5");
    send_byte(B_CLR); send_byte("!"); send_byte("z");
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(B_COLOR); send_byte("@"); send_byte("9"); send_byte(8'h00, 1);
    drain();

    random_phase(90);

    write_reg(CFG_STD_LIMIT, 11'd1024);
    write_reg(CFG_EXT_COUNT, 11'd1024);
    write_reg(CFG_DEF_FG, 11'd1023);
    write_reg(CFG_DEF_BG, 11'd1023);
    random_phase(90);

    write_reg(CFG_STD_LIMIT, 11'd1);
    write_reg(CFG_EXT_COUNT, 11'd1);
    write_reg(CFG_DEF_FG, 11'd0);
    write_reg(CFG_DEF_BG, 11'd512);
    fork
      begin repeat (8) @(negedge clk); hold_rx = 1; end
      random_phase(90);
    join

    write_reg(CFG_STD_LIMIT, 11'($urandom_range(2, 99)));
    write_reg(CFG_EXT_COUNT, 11'($urandom_range(2, 1023)));
    write_reg(CFG_DEF_FG, 11'($urandom_range(0, 1023)));
    write_reg(CFG_DEF_BG, 11'($urandom_range(0, 1023)));
    random_phase(70);

    if (fail_count == 0) $display("tb_color_attribute_code_decoder_unit OK");
    else $display("tb_color_attribute_code_decoder_unit NOT OK");
    $finish;
  end

endmodule
